// ===== hdl/rgbyc_pkg.sv =====
package rgbyc_pkg;

   // register indexes on the configuration port
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

   // configuration widths and reset values
   localparam int unsigned CSR_DATA_W   = 13;
   localparam int unsigned CSR_INDEX_W  = 2;
   localparam int unsigned ROW_W        = 13;
   localparam int unsigned SIZE_W       = 14;
   localparam logic [12:0] WIDTH_RESET  = 13'd1280;
   localparam logic [12:0] HEIGHT_RESET = 13'd960;

   // default widest frame
   localparam int unsigned MAX_WIDTH_DEF = 4096;

   // bt.601 style coefficients, 16 fractional bits
   localparam logic [15:0] COEF_Y_R = 16'd19595;
   localparam logic [15:0] COEF_Y_G = 16'd38470;
   localparam logic [15:0] COEF_Y_B = 16'd7471;
   localparam logic signed [17:0] COEF_CB = 18'sd37028;
   localparam logic signed [17:0] COEF_CR = 18'sd46727;
   localparam logic signed [10:0] CHROMA_OFFSET = 11'sd128;

   // one pixel
   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } pixel_type;

   // horizontal pair sums kept in the line buffer
   typedef struct packed {
      logic [8:0] r;
      logic [8:0] g;
      logic [8:0] b;
   } pair_sum_type;

   // pixel as it leaves the front end
   typedef struct packed {
      logic         vld;
      logic         chroma;
      pixel_type    pix;
      pair_sum_type sum;
   } front_stage_type;

   // one result transaction
   typedef struct packed {
      logic       chroma_valid;
      logic [7:0] luma;
      logic [7:0] cb;
      logic [7:0] cr;
   } result_type;

endpackage

// ===== hdl/rgbyc_line_mem.sv =====
module rgbyc_line_mem
   import rgbyc_pkg::*;
#(
   parameter int unsigned DEPTH  = MAX_WIDTH_DEF / 2,
   parameter int unsigned ADDR_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  pair_sum_type      wr_data,
   output pair_sum_type      rd_data
);

   pair_sum_type mem [DEPTH];
   pair_sum_type rd_data_ff;

   // single port line buffer, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/rgbyc_color_pipe.sv =====
module rgbyc_color_pipe
   import rgbyc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  front_stage_type front,
   input  pair_sum_type    line_data,
   output logic            out_vld,
   output result_type      result
);

   // averages stage
   logic      avg_vld_ff, avg_chroma_ff;
   pixel_type avg_pix_ff, avg_ff;

   // product stage
   logic        prod_vld_ff, prod_chroma_ff;
   logic [23:0] py_r_ff, py_g_ff, py_b_ff;
   logic [23:0] pb_r_ff, pb_g_ff, pb_b_ff;
   logic [7:0]  prod_avg_r_ff, prod_avg_b_ff;

   // difference stage
   logic              diff_vld_ff, diff_chroma_ff;
   logic [7:0]        diff_luma_ff;
   logic signed [8:0] db_ff, dr_ff;

   // chroma product stage
   logic               cp_vld_ff, cp_chroma_ff;
   logic [7:0]         cp_luma_ff;
   logic signed [25:0] cbp_ff, crp_ff;

   // output register
   logic       out_vld_ff;
   result_type result_ff;

   logic [9:0]  sum4_r, sum4_g, sum4_b;
   logic [23:0] y_sum, yb_sum;
   logic [7:0]  yb;
   logic signed [9:0]  cb_shift, cr_shift;
   logic signed [10:0] cb_in, cr_in;
   logic [7:0]  cb_clamp, cr_clamp;

   // four-pixel sums of the block
   assign sum4_r = 10'(line_data.r) + 10'(front.sum.r);
   assign sum4_g = 10'(line_data.g) + 10'(front.sum.g);
   assign sum4_b = 10'(line_data.b) + 10'(front.sum.b);

   always_ff @(posedge clock) begin
      if (advance) begin
         avg_pix_ff <= front.pix;
         avg_ff.r   <= sum4_r[9:2];
         avg_ff.g   <= sum4_g[9:2];
         avg_ff.b   <= sum4_b[9:2];
         avg_chroma_ff <= front.chroma;
      end
   end

   // luma products for the pixel and for the block average
   always_ff @(posedge clock) begin
      if (advance) begin
         py_r_ff <= 24'(avg_pix_ff.r) * 24'(COEF_Y_R);
         py_g_ff <= 24'(avg_pix_ff.g) * 24'(COEF_Y_G);
         py_b_ff <= 24'(avg_pix_ff.b) * 24'(COEF_Y_B);
         pb_r_ff <= 24'(avg_ff.r) * 24'(COEF_Y_R);
         pb_g_ff <= 24'(avg_ff.g) * 24'(COEF_Y_G);
         pb_b_ff <= 24'(avg_ff.b) * 24'(COEF_Y_B);
         prod_avg_r_ff  <= avg_ff.r;
         prod_avg_b_ff  <= avg_ff.b;
         prod_chroma_ff <= avg_chroma_ff;
      end
   end

   // luma and color differences
   assign y_sum  = py_r_ff + py_g_ff + py_b_ff;
   assign yb_sum = pb_r_ff + pb_g_ff + pb_b_ff;
   assign yb     = yb_sum[23:16];

   always_ff @(posedge clock) begin
      if (advance) begin
         diff_luma_ff   <= y_sum[23:16];
         db_ff          <= $signed({1'b0, prod_avg_b_ff}) - $signed({1'b0, yb});
         dr_ff          <= $signed({1'b0, prod_avg_r_ff}) - $signed({1'b0, yb});
         diff_chroma_ff <= prod_chroma_ff;
      end
   end

   // scaled differences
   always_ff @(posedge clock) begin
      if (advance) begin
         cbp_ff       <= 26'(db_ff) * 26'(COEF_CB);
         crp_ff       <= 26'(dr_ff) * 26'(COEF_CR);
         cp_luma_ff   <= diff_luma_ff;
         cp_chroma_ff <= diff_chroma_ff;
      end
   end

   // floor shift, offset and clamp
   assign cb_shift = cbp_ff[25:16];
   assign cr_shift = crp_ff[25:16];
   assign cb_in    = 11'(cb_shift) + CHROMA_OFFSET;
   assign cr_in    = 11'(cr_shift) + CHROMA_OFFSET;

   always_comb begin
      if (cb_in < 0) begin
         cb_clamp = 8'd0;
      end else if (cb_in > 11'sd255) begin
         cb_clamp = 8'd255;
      end else begin
         cb_clamp = cb_in[7:0];
      end
      if (cr_in < 0) begin
         cr_clamp = 8'd0;
      end else if (cr_in > 11'sd255) begin
         cr_clamp = 8'd255;
      end else begin
         cr_clamp = cr_in[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff.luma         <= cp_luma_ff;
         result_ff.chroma_valid <= cp_chroma_ff;
         result_ff.cb           <= cp_chroma_ff ? cb_clamp : 8'd0;
         result_ff.cr           <= cp_chroma_ff ? cr_clamp : 8'd0;
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         avg_vld_ff  <= 1'b0;
         prod_vld_ff <= 1'b0;
         diff_vld_ff <= 1'b0;
         cp_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else if (advance) begin
         avg_vld_ff  <= front.vld;
         prod_vld_ff <= avg_vld_ff;
         diff_vld_ff <= prod_vld_ff;
         cp_vld_ff   <= diff_vld_ff;
         out_vld_ff  <= cp_vld_ff;
      end
   end

   assign out_vld = out_vld_ff;
   assign result  = result_ff;

endmodule

// ===== hdl/rgb_to_ycbcr420_converter_top.sv =====
// RGB to YCbCr 4:2:0 converter
//
// req_* takes 8-bit RGB pixels in raster order, one transaction per pixel.
// rsp_* gives one transaction per pixel: the pixel's luma, and on the pixel
// at odd row and odd column also the chroma pair of the completed 2x2 block
// (rsp_tuser high; cb and cr read zero otherwise).
// csr_* writes frame_width (index 0) and frame_height (index 1); the user must
// do these writes only while idle, which the block itself does not enforce.
// Throughput is one pixel per cycle while the receiver does not stall: the
// line buffer is a single port memory with registered read, and only pixels
// at odd columns use it, writing on even rows and reading on odd rows, never
// both. A result passes through the front register, averaging, luma products,
// differences, chroma products and the output register.
// Reset clears the row and column counters, the pipeline and sets the frame
// size to 1280 x 960; the line buffer is not cleared, since every odd row
// entry is written by the even row before it.
// When the receiver stalls the whole pipeline holds and req_tready drops.
module rgb_to_ycbcr420_converter_top
   import rgbyc_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // pixel input
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [23:0]            req_tdata,   // red, green, blue
   // result output
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [23:0]            rsp_tdata,   // luma, cb, cr
   output logic                   rsp_tuser    // chroma_valid
);

   localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
   localparam int unsigned ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int unsigned COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam logic [SIZE_W-1:0] WIDTH_LIM = SIZE_W'(MAX_WIDTH - (MAX_WIDTH % 2));

   logic [CSR_DATA_W-1:0] width_ff, height_ff;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   pixel_type             held_ff, pix;
   front_stage_type       front_ff, front_in;

   logic [SIZE_W-1:0] width_even, height_even, eff_width, eff_height;
   logic [SIZE_W-1:0] col_next, row_next;
   logic              advance, accept, odd_col, odd_row;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_addr;
   pair_sum_type      line_data;
   logic              out_vld;
   result_type        result;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_addr)
            REG_FRAME_WIDTH:  width_ff  <= csr_wdata;
            REG_FRAME_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective frame size: even, at least two, width limited by the buffer
   assign width_even  = {1'b0, width_ff[CSR_DATA_W-1:1], 1'b0};
   assign height_even = {1'b0, height_ff[CSR_DATA_W-1:1], 1'b0};

   always_comb begin
      if (width_even < SIZE_W'(2)) begin
         eff_width = SIZE_W'(2);
      end else if (width_even > WIDTH_LIM) begin
         eff_width = WIDTH_LIM;
      end else begin
         eff_width = width_even;
      end
      if (height_even < SIZE_W'(2)) begin
         eff_height = SIZE_W'(2);
      end else begin
         eff_height = height_even;
      end
   end

   // handshake: the pipeline moves whenever the output slot frees up
   assign advance    = !out_vld || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   assign pix.r   = req_tdata[7:0];
   assign pix.g   = req_tdata[15:8];
   assign pix.b   = req_tdata[23:16];
   assign odd_col = col_ff[0];
   assign odd_row = row_ff[0];

   // raster position
   assign col_next = SIZE_W'(col_ff) + SIZE_W'(1);
   assign row_next = SIZE_W'(row_ff) + SIZE_W'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_next >= eff_width) begin
            col_in = '0;
            if (row_next >= eff_height) begin
               row_in = '0;
            end else begin
               row_in = row_next[ROW_W-1:0];
            end
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         held_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (accept && !odd_col) begin
            held_ff <= pix;
         end
      end
   end

   // horizontal pair sum and front register
   always_comb begin
      front_in.vld    = accept;
      front_in.chroma = odd_col && odd_row;
      front_in.pix    = pix;
      front_in.sum.r  = 9'(held_ff.r) + 9'(pix.r);
      front_in.sum.g  = 9'(held_ff.g) + 9'(pix.g);
      front_in.sum.b  = 9'(held_ff.b) + 9'(pix.b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.vld <= 1'b0;
      end else if (advance) begin
         front_ff.vld <= front_in.vld;
      end
      if (advance) begin
         front_ff.chroma <= front_in.chroma;
         front_ff.pix    <= front_in.pix;
         front_ff.sum    <= front_in.sum;
      end
   end

   // line buffer: even rows store pair sums, odd rows fetch them
   assign mem_we   = accept && odd_col && !odd_row;
   assign mem_re   = accept && odd_col && odd_row;
   assign mem_addr = ADDR_W'(SIZE_W'(col_ff) >> 1);

   rgbyc_line_mem #(
      .DEPTH  (LINE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .rd_en   (mem_re),
      .addr    (mem_addr),
      .wr_data (front_in.sum),
      .rd_data (line_data)
   );

   rgbyc_color_pipe u_color_pipe (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .front     (front_ff),
      .line_data (line_data),
      .out_vld   (out_vld),
      .result    (result)
   );

   assign rsp_tvalid = out_vld;
   assign rsp_tdata  = {result.cr, result.cb, result.luma};
   assign rsp_tuser  = result.chroma_valid;

   // chroma fields stay zero on luma-only results
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[23:8] == 16'd0))
      else $error("chroma fields not zero without chroma_valid");

   // the line buffer port is never asked to read and write together
   assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("line buffer read and write in the same cycle");

   // a freshly loaded block completion always comes with a line buffer fetch
   assert property (@(posedge clock) disable iff (reset)
      (front_ff.vld && front_ff.chroma && $past(advance)) |-> $past(mem_re))
      else $error("block completion without line buffer fetch");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import rgbyc_pkg::*;

   // write index that the block has no register behind
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;

   localparam int unsigned LINE_DEPTH = MAX_WIDTH_DEF / 2;
   localparam int unsigned WIDTH_CAP = MAX_WIDTH_DEF - (MAX_WIDTH_DEF % 2);

   // luma and chroma weights, 16 fractional bits
   localparam int Y_R_WEIGHT = 19595;
   localparam int Y_G_WEIGHT = 38470;
   localparam int Y_B_WEIGHT = 7471;
   localparam int CB_WEIGHT = 37028;
   localparam int CR_WEIGHT = 46727;
   localparam int CHROMA_MID = 128;

   localparam int DIRECTED_ROWS = 27;
   localparam int PHASE_COUNT = 22;
   localparam int TALL_PHASE = 2;
   localparam int PRESSURE_PHASE = 4;
   localparam int WIDE_PHASE = 10;
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;

   // one row of the directed table: a register write or a pixel
   typedef struct packed {
      logic                   is_write;
      logic [CSR_INDEX_W-1:0] addr;
      logic [CSR_DATA_W-1:0]  data;
      pixel_type              pix;
      logic                   typed;
      result_type             res;
   } vector_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_addr = REG_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [23:0]            req_tdata = '0;   // red, green, blue
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [23:0]            rsp_tdata;        // luma, cb, cr
   logic                   rsp_tuser;        // chroma_valid

   // converted pixels not yet seen on the result side
   result_type ycbcr_due [$];
   bit run_failed = 1'b0;
   bit calm_phase = 1'b0;
   bit long_hold_req = 1'b0;
   int unsigned quiet_cycles = 0;

   // predictor state
   logic [CSR_DATA_W-1:0] width_reg;
   logic [CSR_DATA_W-1:0] height_reg;
   pair_sum_type pair_line [LINE_DEPTH];
   pixel_type held_pix;
   int unsigned col_pos;
   int unsigned row_pos;

   rgb_to_ycbcr420_converter_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int luma_weighted(input int r, input int g, input int b);
      return (Y_R_WEIGHT * r + Y_G_WEIGHT * g + Y_B_WEIGHT * b) >>> 16;
   endfunction

   function automatic logic [7:0] clamp_byte(input int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return 8'(v);
   endfunction

   // advance the predictor by one pixel and give its result
   task automatic convert_pixel(input pixel_type p, output result_type res);
      int unsigned w, h, slot;
      int sr, sg, sb, ar, ag, ab, yb;
      pair_sum_type stored;
      w = width_reg & 13'h1FFE;
      if (w < 2) w = 2;
      if (w > WIDTH_CAP) w = WIDTH_CAP;
      h = height_reg & 13'h1FFE;
      if (h < 2) h = 2;
      slot = col_pos >> 1;
      res = '0;
      res.luma = 8'(luma_weighted(int'(p.r), int'(p.g), int'(p.b)));
      if (!col_pos[0]) begin
         held_pix = p;
      end else begin
         sr = int'(held_pix.r) + int'(p.r);
         sg = int'(held_pix.g) + int'(p.g);
         sb = int'(held_pix.b) + int'(p.b);
         if (!row_pos[0]) begin
            // even row: keep the horizontal pair sums for the row below
            if (slot < LINE_DEPTH) begin
               pair_line[slot] = '{r: 9'(sr), g: 9'(sg), b: 9'(sb)};
            end
         end else begin
            // odd row: finish the 2x2 block
            stored = (slot < LINE_DEPTH) ? pair_line[slot] : '0;
            ar = (int'(stored.r) + sr) >>> 2;
            ag = (int'(stored.g) + sg) >>> 2;
            ab = (int'(stored.b) + sb) >>> 2;
            yb = luma_weighted(ar, ag, ab);
            res.chroma_valid = 1'b1;
            res.cb = clamp_byte(CHROMA_MID + (((ab - yb) * CB_WEIGHT) >>> 16));
            res.cr = clamp_byte(CHROMA_MID + (((ar - yb) * CR_WEIGHT) >>> 16));
         end
      end
      // raster position, wrapping under the current size
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         if (row_pos + 1 >= h) row_pos = 0;
         else row_pos++;
      end else begin
         col_pos++;
      end
   endtask

   function automatic logic [7:0] random_component();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type p;
      p.r = random_component();
      p.g = random_component();
      p.b = random_component();
      return p;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] choose_width();
      case ($urandom_range(0, 9))
         0: return 13'($urandom_range(0, 1));
         1, 2: return 13'($urandom_range(41, 300));
         default: return 13'($urandom_range(2, 40));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] choose_height();
      case ($urandom_range(0, 9))
         0: return 13'($urandom_range(0, 1));
         1: return 13'($urandom);
         default: return 13'($urandom_range(2, 10));
      endcase
   endfunction

   function automatic vector_type stim_pixel(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b, input logic typed,
                                             input logic [7:0] luma, input logic chroma,
                                             input logic [7:0] cb, input logic [7:0] cr);
      vector_type v;
      v = '0;
      v.pix = '{r: r, g: g, b: b};
      v.typed = typed;
      v.res = '{chroma_valid: chroma, luma: luma, cb: cb, cr: cr};
      return v;
   endfunction

   function automatic vector_type stim_write(input logic [CSR_INDEX_W-1:0] addr,
                                             input logic [CSR_DATA_W-1:0] data);
      vector_type v;
      v = '0;
      v.is_write = 1'b1;
      v.addr = addr;
      v.data = data;
      return v;
   endfunction

   // offer one pixel, predict it once the transaction is taken
   task automatic send_pixel(input pixel_type p, input logic typed, input result_type typed_res);
      result_type due;
      if (!calm_phase && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {p.b, p.g, p.r};
      do @(posedge clock); while (!req_tready);
      convert_pixel(p, due);
      ycbcr_due.push_back(typed ? typed_res : due);
   endtask

   // stop offering and wait for every pending result
   task automatic settle_pipeline();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (ycbcr_due.size() != 0);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      settle_pipeline();
      csr_wr_en <= 1'b1;
      csr_addr <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (index)
         REG_FRAME_WIDTH: width_reg = value;
         REG_FRAME_HEIGHT: height_reg = value;
         default: ;
      endcase
   endtask

   task automatic resize_frame(input logic [CSR_DATA_W-1:0] new_width,
                               input logic [CSR_DATA_W-1:0] new_height);
      // finish an odd row first, so every line entry read later was written above it
      while (row_pos[0]) send_pixel(random_pixel(), 1'b0, '0);
      write_register(REG_FRAME_WIDTH, new_width);
      write_register(REG_FRAME_HEIGHT, new_height);
      if ($urandom_range(0, 3) == 0) write_register(REG_UNUSED, 13'($urandom));
   endtask

   // receiver: random stalls, one long hold-off on request
   initial begin : result_sink
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic bit field_ok(input string label, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // result side: compare each transaction with the oldest prediction
   always @(posedge clock) begin : check_results
      result_type due;
      bit ok;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (ycbcr_due.size() == 0) begin
            $display("%0t: result with no pixel pending, luma %0d", $time, rsp_tdata[7:0]);
            run_failed = 1'b1;
         end else begin
            due = ycbcr_due.pop_front();
            ok = field_ok("luma", due.luma, rsp_tdata[7:0]);
            ok = field_ok("chroma_valid", due.chroma_valid, rsp_tuser) & ok;
            ok = field_ok("cb", due.cb, rsp_tdata[15:8]) & ok;
            ok = field_ok("cr", due.cr, rsp_tdata[23:16]) & ok;
            if (!ok) run_failed = 1'b1;
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin : stimulus
      vector_type directed_vectors [DIRECTED_ROWS];
      int unsigned item_count;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      held_pix = '0;
      col_pos = 0;
      row_pos = 0;

      // extremes at reset size, then tiny size set mid-row, then whole blocks
      directed_vectors = '{
         stim_pixel(8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 1'b0, 8'd0, 8'd0),
         stim_pixel(8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 1'b0, 8'd0, 8'd0),
         stim_pixel(8'd255, 8'd0, 8'd0, 1'b1, 8'd76, 1'b0, 8'd0, 8'd0),
         stim_pixel(8'd0, 8'd255, 8'd0, 1'b1, 8'd149, 1'b0, 8'd0, 8'd0),
         stim_pixel(8'd0, 8'd0, 8'd255, 1'b1, 8'd29, 1'b0, 8'd0, 8'd0),
         stim_write(REG_FRAME_WIDTH, 13'd1),
         stim_write(REG_FRAME_HEIGHT, 13'd0),
         stim_write(REG_UNUSED, 13'h1FFF),
         stim_pixel(8'd0, 8'd0, 8'd255, 1'b1, 8'd29, 1'b0, 8'd0, 8'd0),
         stim_pixel(8'd0, 8'd0, 8'd255, 1'b1, 8'd29, 1'b0, 8'd0, 8'd0),
         stim_pixel(8'd0, 8'd0, 8'd255, 1'b0, 8'd0, 1'b0, 8'd0, 8'd0),
         stim_pixel(8'd0, 8'd0, 8'd255, 1'b1, 8'd29, 1'b0, 8'd0, 8'd0),
         stim_pixel(8'd0, 8'd0, 8'd255, 1'b1, 8'd29, 1'b0, 8'd0, 8'd0),
         stim_pixel(8'd0, 8'd0, 8'd255, 1'b1, 8'd29, 1'b0, 8'd0, 8'd0),
         stim_pixel(8'd0, 8'd0, 8'd255, 1'b0, 8'd0, 1'b0, 8'd0, 8'd0),
         stim_pixel(8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 1'b0, 8'd0, 8'd0),
         stim_pixel(8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 1'b0, 8'd0, 8'd0),
         stim_pixel(8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 1'b0, 8'd0, 8'd0),
         stim_pixel(8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 1'b1, 8'd128, 8'd128),
         stim_pixel(8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 1'b0, 8'd0, 8'd0),
         stim_pixel(8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 1'b0, 8'd0, 8'd0),
         stim_pixel(8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 1'b0, 8'd0, 8'd0),
         stim_pixel(8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 1'b1, 8'd128, 8'd128),
         stim_pixel(8'd255, 8'd0, 8'd0, 1'b1, 8'd76, 1'b0, 8'd0, 8'd0),
         stim_pixel(8'd255, 8'd0, 8'd0, 1'b1, 8'd76, 1'b0, 8'd0, 8'd0),
         stim_pixel(8'd255, 8'd0, 8'd0, 1'b1, 8'd76, 1'b0, 8'd0, 8'd0),
         stim_pixel(8'd255, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 8'd0)
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_vectors[i]) begin
         if (directed_vectors[i].is_write) begin
            write_register(directed_vectors[i].addr, directed_vectors[i].data);
         end else begin
            send_pixel(directed_vectors[i].pix, directed_vectors[i].typed,
                       directed_vectors[i].res);
         end
      end

      // random phases, each under its own frame size
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         calm_phase = (phase >= PHASE_COUNT - 3);
         if (phase == WIDE_PHASE) begin
            // saturated width, a stretch of one even row
            resize_frame(13'h1FFF, 13'd2);
         end else begin
            resize_frame(choose_width(), (phase == TALL_PHASE) ? 13'h1FFF : choose_height());
         end
         item_count = (phase == PRESSURE_PHASE) ? 60 : $urandom_range(8, 28);
         if (phase == PRESSURE_PHASE) long_hold_req = 1'b1;
         repeat (item_count) send_pixel(random_pixel(), 1'b0, '0);
      end

      settle_pipeline();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!run_failed && ycbcr_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/rgbyc_pkg.sv
hdl/rgbyc_line_mem.sv
hdl/rgbyc_color_pipe.sv
hdl/rgb_to_ycbcr420_converter_top.sv
tb/sv/testbench.sv
